[rtl/core/gpd_pkg.sv]
// gpd_pkg: shared types and constants for the gyro packet deframer
// used by every module under rtl/core; no dependencies of its own
package gpd_pkg;

  localparam int unsigned WIN_LEN   = 8;
  localparam int unsigned CNT_W     = 4;
  localparam logic [7:0]  HDR_BYTE  = 8'hFF;
  localparam logic [CNT_W-1:0] CHECK_AT = CNT_W'(WIN_LEN);

  typedef logic [7:0]         byte_t;
  typedef logic signed [15:0] word_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef byte_t [WIN_LEN-1:0] win_t;

  // result of checking one window
  typedef struct packed {
    logic  pass;
    word_t rate;
    word_t position;
  } chk_t;

endpackage

[rtl/core/gpd_byte_cell.sv]
// gpd_byte_cell: one byte of the receive window, loads from its neighbour
// depends on gpd_pkg
module gpd_byte_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  gpd_pkg::byte_t d_in,
  output gpd_pkg::byte_t q_out
);
  import gpd_pkg::*;

  byte_t byte_r;
  byte_t byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? d_in : byte_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q_out = byte_r;

endmodule

[rtl/core/gpd_check.sv]
// gpd_check: header and checksum test on one 8-byte window
// depends on gpd_pkg
module gpd_check (
  input  gpd_pkg::win_t win,
  output gpd_pkg::chk_t chk
);
  import gpd_pkg::*;

  logic [15:0] rate_w;
  logic [15:0] pos_w;
  logic [15:0] sum_w;
  logic [15:0] expect_w;
  logic        hdr_ok;

  always_comb begin
    rate_w   = {win[3], win[2]};
    pos_w    = {win[5], win[4]};
    sum_w    = {win[7], win[6]};
    // checksum is rate plus position minus one, wrapping at 16 bits
    expect_w = rate_w + pos_w - 16'd1;
    hdr_ok   = (win[0] == HDR_BYTE) && (win[1] == HDR_BYTE);
    chk.pass     = hdr_ok && (expect_w == sum_w);
    chk.rate     = word_t'(rate_w);
    chk.position = word_t'(pos_w);
  end

endmodule

[rtl/core/gyro_packet_deframer_core.sv]
// gyro_packet_deframer_core: top level of the gyro packet deframer
// depends on gpd_pkg, gpd_byte_cell and gpd_check
//
// One received serial byte enters per transaction and one transaction can be
// taken in every clock cycle. The bytes pass down a row of eight byte cells
// that form the packet window (oldest first). A packet is two 0xFF header
// bytes, little-endian rate, little-endian position and a little-endian
// checksum equal to rate + position - 1 modulo 2^16. In sync mode the window
// is tested once every eight bytes; a failed test drops to hunt mode, where
// the window is tested after every byte until a packet passes. Each passing
// packet yields one output transaction carrying rate and position; nothing
// else is produced. The test runs on the window as it will be after the
// incoming byte, so the result is registered with the byte that completes
// the packet (in the skid stage if the output register is held). An output
// register plus a one-entry skid stage sit in front of the output, so input
// keeps flowing while a result waits; input stalls only when both hold one.
module gyro_packet_deframer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  out_rate,
  output logic signed [15:0]  out_position
);
  import gpd_pkg::*;

  // window cells
  win_t win_q;
  win_t win_next;
  logic in_fire;

  // sync tracking
  logic in_sync_r, in_sync_nxt;
  cnt_t cnt_r, cnt_nxt;
  cnt_t cnt_inc;
  logic do_check;

  // check result
  chk_t chk;
  logic push;

  // output register and skid stage
  logic  out_valid_r, out_valid_nxt;
  word_t out_rate_r, out_rate_nxt;
  word_t out_pos_r, out_pos_nxt;
  logic  skid_valid_r, skid_valid_nxt;
  word_t skid_rate_r, skid_rate_nxt;
  word_t skid_pos_r, skid_pos_nxt;
  logic  out_free;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;

  // row of byte cells, each loads from the next one up; the top cell
  // takes the incoming byte
  genvar gi;
  generate
    for (gi = 0; gi < WIN_LEN; gi++) begin : g_cell
      if (gi == WIN_LEN - 1) begin : g_top
        assign win_next[gi] = in_rx_byte;
      end else begin : g_mid
        assign win_next[gi] = win_q[gi+1];
      end
      gpd_byte_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (in_fire),
        .d_in     (win_next[gi]),
        .q_out    (win_q[gi])
      );
    end
  endgenerate

  // test the window as it stands after this byte
  gpd_check u_check (
    .win (win_next),
    .chk (chk)
  );

  always_comb begin
    cnt_inc     = cnt_r + cnt_t'(1);
    // in hunt mode every byte is tested; in sync mode every eighth byte
    do_check    = !in_sync_r || (cnt_inc >= CHECK_AT) || (cnt_inc == '0);
    in_sync_nxt = in_sync_r;
    cnt_nxt     = cnt_r;
    push        = 1'b0;
    if (in_fire) begin
      cnt_nxt = in_sync_r ? cnt_inc : '0;
      if (do_check) begin
        cnt_nxt     = '0;
        in_sync_nxt = chk.pass;
        push        = chk.pass;
      end
    end
  end

  // output side: skid entry drains first, a fresh result goes to the
  // output register if it is free, otherwise into the skid stage
  always_comb begin
    out_free       = !out_valid_r || out_ready;
    out_valid_nxt  = out_valid_r;
    out_rate_nxt   = out_rate_r;
    out_pos_nxt    = out_pos_r;
    skid_valid_nxt = skid_valid_r;
    skid_rate_nxt  = skid_rate_r;
    skid_pos_nxt   = skid_pos_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_rate_nxt   = skid_rate_r;
        out_pos_nxt    = skid_pos_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        if (push) begin
          out_rate_nxt = chk.rate;
          out_pos_nxt  = chk.position;
        end
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_rate_nxt  = chk.rate;
      skid_pos_nxt   = chk.position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sync_r    <= 1'b1;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      in_sync_r    <= in_sync_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    out_rate_r  <= out_rate_nxt;
    out_pos_r   <= out_pos_nxt;
    skid_rate_r <= skid_rate_nxt;
    skid_pos_r  <= skid_pos_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_rate     = out_rate_r;
  assign out_position = out_pos_r;

endmodule
